### rtl/pvpt_pkg.sv
`timescale 1ns / 1ps

package pvpt_pkg;

  localparam int ACC_W = 66;

  // Transaction kinds on req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  // Word addresses in the parameter memory.
  localparam logic [5:0] ADDR_VIEW_Y = 6'd4;
  localparam logic [5:0] ADDR_VIEW_W = 6'd12;
  localparam logic [5:0] ADDR_PROJ   = 6'd16;
  localparam logic [5:0] ADDR_ORG_X  = 6'd32;
  localparam logic [5:0] ADDR_ORG_Y  = 6'd33;
  localparam logic [5:0] ADDR_SIZE_W = 6'd34;
  localparam logic [5:0] ADDR_SIZE_H = 6'd35;
  localparam logic [5:0] ADDR_WORDS  = 6'd36;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_STORE, S_CHKW, S_DIV, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_EYE, PH_CLIP, PH_MAPX, PH_MAPY} phase_t;

  typedef enum logic [2:0] {OP_X, OP_Y, OP_ONE, OP_EYE, OP_NDC1, OP_TWO_ONE} opnd_sel_t;

  typedef enum logic {ACC_RAW, ACC_SCALE} acc_mode_t;

  typedef enum logic [2:0] {ST_EYE, ST_CLIP, ST_OUTX, ST_OUTY, ST_ZERO} store_sel_t;

  typedef struct packed {
    logic       wr_en;
    logic       latch;
    logic       rd_en;
    logic [5:0] rd_addr;
    opnd_sel_t  opnd;
    logic [1:0] opnd_idx;
    logic       mul_en;
    logic       acc_en;
    acc_mode_t  acc_mode;
    logic       store_en;
    store_sel_t store;
    logic [1:0] store_idx;
    logic       div_start;
    logic       div_axis;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic w_is_zero;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > $signed(ACC_W'(32'sh7FFF_FFFF))) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -$signed(ACC_W'(33'sh0_8000_0000))) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > $signed(ACC_W'(16'sh7FFF))) begin
      return 16'sh7FFF;
    end else if (v < -$signed(ACC_W'(17'sh0_8000))) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

### rtl/pvpt_datapath.sv
`timescale 1ns / 1ps

module pvpt_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pvpt_pkg::cmd_t      cmd,
  output pvpt_pkg::status_t   status,
  input  logic [5:0]          word_index,
  input  logic signed [31:0]  word_value,
  input  logic signed [15:0]  point_x,
  input  logic signed [15:0]  point_y,
  output logic signed [15:0]  native_x,
  output logic signed [15:0]  native_y,
  output logic                w_zero
);

  localparam int ACCW = pvpt_pkg::ACC_W;
  localparam int DIVW = 32 + FRAC_BITS;
  localparam int CNTW = $clog2(DIVW);
  localparam int MAP_SH = 2 * FRAC_BITS + 1;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] TWO_ONE = 32'sd1 <<< (FRAC_BITS + 1);
  localparam logic signed [63:0] ONE_M1 = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [ACCW-1:0] MAP_BIAS = (ACCW'(1) <<< MAP_SH) - ACCW'(1);
  localparam logic [DIVW-1:0] LIM_POS = DIVW'(32'h3FFF_FFFF);
  localparam logic [DIVW-1:0] LIM_NEG = DIVW'(32'h4000_0000);

  logic [31:0] mem [36];
  logic signed [31:0] rdata;
  logic signed [15:0] px, py;
  logic signed [31:0] eye [4];
  logic signed [31:0] clip [4];
  logic signed [31:0] opnd;
  logic signed [63:0] prod;
  logic signed [63:0] scaled;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] acc_add;
  logic signed [ACCW-1:0] map_shift;

  logic [31:0] rem;
  logic [31:0] den;
  logic [DIVW-1:0] quo;
  logic [CNTW-1:0] cnt;
  logic neg;
  logic div_busy;
  logic [32:0] trial;
  logic signed [31:0] ndc;
  logic signed [31:0] clip_sel;
  logic [31:0] clip_mag;
  logic [31:0] w_mag;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (word_index < pvpt_pkg::ADDR_WORDS)) begin
      mem[word_index] <= word_value;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr];
    end
  end

  // The translation column is already in Q.F, so it is taken with a weight of one.
  always_comb begin
    case (cmd.opnd)
      pvpt_pkg::OP_X:    opnd = 32'(px);
      pvpt_pkg::OP_Y:    opnd = 32'(py);
      pvpt_pkg::OP_ONE:  opnd = 32'sd1;
      pvpt_pkg::OP_EYE:  opnd = eye[cmd.opnd_idx];
      pvpt_pkg::OP_NDC1: opnd = ndc + ONE;
      default:           opnd = TWO_ONE;
    endcase
  end

  assign scaled = (prod + (prod[63] ? ONE_M1 : 64'sd0)) >>> FRAC_BITS;
  assign acc_add = (cmd.acc_mode == pvpt_pkg::ACC_SCALE) ? ACCW'(scaled) : ACCW'(prod);
  assign map_shift = (acc + (acc[ACCW-1] ? MAP_BIAS : ACCW'(0))) >>> MAP_SH;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px <= point_x;
      py <= point_y;
    end
    if (cmd.mul_en) begin
      prod <= rdata * opnd;
    end
    if (cmd.latch || cmd.store_en) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + acc_add;
    end
    if (cmd.store_en) begin
      case (cmd.store)
        pvpt_pkg::ST_EYE:  eye[cmd.store_idx] <= pvpt_pkg::sat32(acc);
        pvpt_pkg::ST_CLIP: clip[cmd.store_idx] <= pvpt_pkg::sat32(acc);
        pvpt_pkg::ST_OUTX: begin
          native_x <= pvpt_pkg::sat16(map_shift);
          w_zero <= 1'b0;
        end
        pvpt_pkg::ST_OUTY: native_y <= pvpt_pkg::sat16(map_shift);
        default: begin
          native_x <= '0;
          native_y <= '0;
          w_zero <= 1'b1;
        end
      endcase
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign clip_sel = cmd.div_axis ? clip[1] : clip[0];
  assign clip_mag = clip_sel[31] ? 32'(-clip_sel) : clip_sel;
  assign w_mag = clip[3][31] ? 32'(-clip[3]) : clip[3];
  assign trial = {rem, quo[DIVW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && (cnt == '0)) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      den <= w_mag;
      quo <= DIVW'(clip_mag) << FRAC_BITS;
      neg <= clip_sel[31] ^ clip[3][31];
      cnt <= CNTW'(DIVW - 1);
    end else if (div_busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= 32'(trial - {1'b0, den});
        quo <= {quo[DIVW-2:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[DIVW-2:0], 1'b0};
      end
      cnt <= cnt - CNTW'(1);
    end
  end

  always_comb begin
    if (neg) begin
      ndc = (quo > LIM_NEG) ? -32'sh4000_0000 : -$signed(quo[31:0]);
    end else begin
      ndc = (quo > LIM_POS) ? 32'sh3FFF_FFFF : $signed(quo[31:0]);
    end
  end

  assign status.div_busy = div_busy;
  assign status.w_is_zero = (clip[3] == 32'sd0);

endmodule

### rtl/pvpt_controller.sv
`timescale 1ns / 1ps

module pvpt_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              req_type,
  output logic              busy,
  output logic              done,
  output pvpt_pkg::cmd_t    cmd,
  input  pvpt_pkg::status_t status
);

  pvpt_pkg::state_t state, state_next;
  pvpt_pkg::phase_t phase, phase_next;
  logic [1:0] row, row_next;
  logic [1:0] term, term_next;
  logic last_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvpt_pkg::S_IDLE;
      phase <= pvpt_pkg::PH_EYE;
      row <= '0;
      term <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      row <= row_next;
      term <= term_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    row_next = row;
    term_next = term;
    cmd = '0;
    busy = (state != pvpt_pkg::S_IDLE);
    done = 1'b0;
    last_term = 1'b0;

    unique case (phase)
      pvpt_pkg::PH_EYE: begin
        last_term = (term == 2'd2);
        unique case (term)
          2'd0: begin
            cmd.rd_addr = {4'd0, row};
            cmd.opnd = pvpt_pkg::OP_X;
          end
          2'd1: begin
            cmd.rd_addr = pvpt_pkg::ADDR_VIEW_Y + {4'd0, row};
            cmd.opnd = pvpt_pkg::OP_Y;
          end
          default: begin
            cmd.rd_addr = pvpt_pkg::ADDR_VIEW_W + {4'd0, row};
            cmd.opnd = pvpt_pkg::OP_ONE;
          end
        endcase
        cmd.store = pvpt_pkg::ST_EYE;
      end
      pvpt_pkg::PH_CLIP: begin
        last_term = (term == 2'd3);
        cmd.rd_addr = pvpt_pkg::ADDR_PROJ + {2'd0, term, 2'd0} + {4'd0, row};
        cmd.opnd = pvpt_pkg::OP_EYE;
        cmd.opnd_idx = term;
        cmd.acc_mode = pvpt_pkg::ACC_SCALE;
        cmd.store = pvpt_pkg::ST_CLIP;
      end
      pvpt_pkg::PH_MAPX: begin
        last_term = (term == 2'd1);
        cmd.rd_addr = (term == 2'd0) ? pvpt_pkg::ADDR_SIZE_W : pvpt_pkg::ADDR_ORG_X;
        cmd.opnd = (term == 2'd0) ? pvpt_pkg::OP_NDC1 : pvpt_pkg::OP_TWO_ONE;
        cmd.store = pvpt_pkg::ST_OUTX;
      end
      default: begin
        last_term = (term == 2'd1);
        cmd.rd_addr = (term == 2'd0) ? pvpt_pkg::ADDR_SIZE_H : pvpt_pkg::ADDR_ORG_Y;
        cmd.opnd = (term == 2'd0) ? pvpt_pkg::OP_NDC1 : pvpt_pkg::OP_TWO_ONE;
        cmd.store = pvpt_pkg::ST_OUTY;
      end
    endcase
    cmd.store_idx = row;

    unique case (state)
      pvpt_pkg::S_IDLE: begin
        if (start) begin
          if (req_type == pvpt_pkg::REQ_POINT) begin
            cmd.latch = 1'b1;
            phase_next = pvpt_pkg::PH_EYE;
            row_next = '0;
            term_next = '0;
            state_next = pvpt_pkg::S_RD;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      pvpt_pkg::S_RD: begin
        cmd.rd_en = 1'b1;
        state_next = pvpt_pkg::S_MUL;
      end
      pvpt_pkg::S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = pvpt_pkg::S_ACC;
      end
      pvpt_pkg::S_ACC: begin
        cmd.acc_en = 1'b1;
        if (last_term) begin
          state_next = pvpt_pkg::S_STORE;
        end else begin
          term_next = term + 2'd1;
          state_next = pvpt_pkg::S_RD;
        end
      end
      pvpt_pkg::S_STORE: begin
        cmd.store_en = 1'b1;
        term_next = '0;
        unique case (phase)
          pvpt_pkg::PH_EYE: begin
            if (row == 2'd3) begin
              phase_next = pvpt_pkg::PH_CLIP;
            end
            row_next = row + 2'd1;
            state_next = pvpt_pkg::S_RD;
          end
          pvpt_pkg::PH_CLIP: begin
            row_next = row + 2'd1;
            state_next = (row == 2'd3) ? pvpt_pkg::S_CHKW : pvpt_pkg::S_RD;
          end
          pvpt_pkg::PH_MAPX: begin
            cmd.div_start = 1'b1;
            cmd.div_axis = 1'b1;
            phase_next = pvpt_pkg::PH_MAPY;
            state_next = pvpt_pkg::S_DIV;
          end
          default: begin
            state_next = pvpt_pkg::S_DONE;
          end
        endcase
      end
      pvpt_pkg::S_CHKW: begin
        term_next = '0;
        if (status.w_is_zero) begin
          cmd.store_en = 1'b1;
          cmd.store = pvpt_pkg::ST_ZERO;
          state_next = pvpt_pkg::S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_axis = 1'b0;
          phase_next = pvpt_pkg::PH_MAPX;
          state_next = pvpt_pkg::S_DIV;
        end
      end
      pvpt_pkg::S_DIV: begin
        if (!status.div_busy) begin
          state_next = pvpt_pkg::S_RD;
        end
      end
      default: begin
        done = 1'b1;
        state_next = pvpt_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == pvpt_pkg::S_IDLE))
    else $error("done not followed by idle");
  a_div_phase: assert property (@(posedge clk) disable iff (rst)
    (state == pvpt_pkg::S_DIV) |-> (phase == pvpt_pkg::PH_MAPX || phase == pvpt_pkg::PH_MAPY))
    else $error("division outside a mapping phase");
  a_store_after_acc: assert property (@(posedge clk) disable iff (rst)
    (state == pvpt_pkg::S_STORE) |-> ($past(state) == pvpt_pkg::S_ACC))
    else $error("store without a final accumulate");
`endif

endmodule

### rtl/point_view_projection_transform_unit.sv
`timescale 1ns / 1ps
// A load transaction completes in its accept cycle and gives no result. A transform
// holds busy from its accept edge through its done strobe, which is high in its last
// busy cycle; the zero-w path skips the divides and mappings. A new transform is
// accepted only once busy is low again. One shared multiplier serves every term and a
// serial divider makes one quotient bit per cycle. Results cannot stall.
// Reset is synchronous and clears control only; matrix words are undefined until loaded.

// Command interface: a transaction is accepted when start is high and busy is low.
// A load transaction writes one word of the parameter memory (modelview, projection,
// viewport) and leaves busy low. A transform transaction raises busy until the
// cycle after the done strobe; native_x, native_y and w_zero are valid while done
// is high and for one cycle only as far as the receiver is concerned.
//
// The controller walks the transform in phases: eye coordinates (three terms per
// row), clip coordinates (four terms per row, each product scaled back to Q.F),
// a zero-w check, then, unless w is zero, for each axis a serial divide followed by
// the two-term viewport mapping.

module point_view_projection_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               req_type,
  input  logic [5:0]         word_index,
  input  logic signed [31:0] word_value,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  output logic signed [15:0] native_x,
  output logic signed [15:0] native_y,
  output logic               w_zero
);

  pvpt_pkg::cmd_t    cmd;
  pvpt_pkg::status_t status;

  pvpt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd),
    .status   (status)
  );

  pvpt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .word_index (word_index),
    .word_value (word_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .native_x   (native_x),
    .native_y   (native_y),
    .w_zero     (w_zero)
  );

endmodule
